[sv/dasg_pkg.sv]
package dasg_pkg;

    // Gate mode codes, as reported in the result
    typedef enum logic [2:0] {
        MODE_DISABLED = 3'd0,
        MODE_WAIT_REM = 3'd1,
        MODE_WAIT_MOT = 3'd2,
        MODE_ARMED    = 3'd3,
        MODE_FAULT    = 3'd4
    } t_mode;

    // Request kind carried on the slave tuser
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 8;

    // Status sample fields, highest bit first
    typedef struct packed {
        logic switch_up;
        logic bus_ok;
        logic motors_up;
        logic link_up;
        logic cfg_ok;
    } t_sample;

    typedef struct packed {
        logic  drive_enable;
        t_mode gate_mode;
    } t_result;

endpackage

[sv/drive_arming_safety_gate.sv]
// Drive arming safety gate.
//
// Slave stream: one request per accepted beat. s_axis_tuser selects the kind:
// a status sample (health flags plus arm switch level in s_axis_tdata) or a
// fault clear request (tdata ignored). Master stream: one result per request,
// in request order, with the gate mode and the drive enable.
//
// Pipeline: an accepted request is held in the input register; the mode
// update and the result are computed from it and land in the output
// register, which drives the master side.
// Throughput: one request per cycle while the master side does not stall.
// The only loop is the mode and switch history update, a few gates wide.
//
// Reset (i_rst_n low, synchronous): both stages empty, mode disabled, switch
// history cleared (switch treated as never seen released).
//
// Stall: while the master side holds tready low, the result register holds
// its request and the input register still takes one more request; after
// that s_axis_tready drops until the master side drains.
module drive_arming_safety_gate
    import dasg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] cfg_ok, [1] link_up, [2] motors_up,
    // [3] bus_ok, [4] switch_up, [7:5] zero
    input  logic [InDataW-1:0]  s_axis_tdata,
    // [0] operation (0 status sample, 1 fault clear)
    input  logic                s_axis_tuser,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [2:0] gate_mode, [3] drive_enable, [7:4] zero
    output logic [OutDataW-1:0] m_axis_tdata
);

    localparam int unsigned SampleW = $bits(t_sample);
    localparam int unsigned ResultW = $bits(t_result);

    // Input register
    logic    r_in_vld;
    t_op     r_in_op;
    t_sample r_in_smp;

    // Output register
    logic    r_out_vld;
    t_result r_out_res;

    // Gate state
    t_mode   r_mode;
    logic    r_last_up;
    logic    r_seen_rel;
    logic    r_rel_after_fault;

    t_mode   n_mode;
    logic    n_last_up;
    logic    n_seen_rel;
    logic    n_rel_after_fault;
    t_result n_res;

    logic    advance;
    logic    in_take;

    // Move the held request into the output stage when it is free or draining
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= t_op'(s_axis_tuser);
            r_in_smp <= t_sample'(s_axis_tdata[SampleW-1:0]);
        end
    end

    // Next state: mode and switch history for the held request
    always_comb begin
        logic rem;
        logic up;
        logic rising;
        logic rel_now;
        logic healthy;

        rem     = r_in_smp.link_up;
        up      = r_in_smp.switch_up;
        rising  = rem && up && !r_last_up;
        rel_now = rem && !up;
        healthy = r_in_smp.cfg_ok && rem && r_in_smp.motors_up
                  && r_in_smp.bus_ok;

        n_mode            = r_mode;
        n_last_up         = r_last_up;
        n_seen_rel        = r_seen_rel;
        n_rel_after_fault = r_rel_after_fault;

        if (r_in_op == OP_CLEAR) begin
            // Leave fault only once the switch went down since the trip
            if (r_mode == MODE_FAULT && r_rel_after_fault) begin
                n_mode            = MODE_DISABLED;
                n_rel_after_fault = 1'b0;
            end
        end else begin
            if (rel_now) begin
                n_seen_rel = 1'b1;
                if (r_mode == MODE_FAULT) begin
                    n_rel_after_fault = 1'b1;
                end
            end

            unique case (r_mode)
                MODE_FAULT: begin
                    n_mode = MODE_FAULT;
                end
                MODE_ARMED: begin
                    if (!healthy) begin
                        n_mode            = MODE_FAULT;
                        n_rel_after_fault = rel_now;
                    end else if (!up) begin
                        n_mode = MODE_DISABLED;
                    end
                end
                default: begin
                    // Disabled, both waiting modes, and any unused code
                    if (!r_in_smp.cfg_ok) begin
                        n_mode = MODE_DISABLED;
                    end else if (!rem) begin
                        n_mode = MODE_WAIT_REM;
                    end else if (!r_in_smp.motors_up || !r_in_smp.bus_ok) begin
                        n_mode = MODE_WAIT_MOT;
                    end else if (r_seen_rel && rising) begin
                        n_mode = MODE_ARMED;
                    end else begin
                        n_mode = MODE_DISABLED;
                    end
                end
            endcase

            // Switch level only counts while the remote link is up
            if (rem) begin
                n_last_up = up;
            end
        end
    end

    // Result for the held request
    always_comb begin
        n_res.gate_mode    = n_mode;
        n_res.drive_enable = (n_mode == MODE_ARMED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_DISABLED;
            r_last_up         <= 1'b0;
            r_seen_rel        <= 1'b0;
            r_rel_after_fault <= 1'b0;
        end else if (advance) begin
            r_mode            <= n_mode;
            r_last_up         <= n_last_up;
            r_seen_rel        <= n_seen_rel;
            r_rel_after_fault <= n_rel_after_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OutDataW-ResultW){1'b0}}, r_out_res};

endmodule

[sv/dasg_checker.sv]
module dasg_checker
    import dasg_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // No result may appear right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The input side is open right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // Drive enable follows the armed mode
    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[3] == (m_axis_tdata[2:0] == MODE_ARMED)))
        else $error("drive enable disagrees with mode");

    // Only defined modes are reported
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= MODE_FAULT))
        else $error("undefined gate mode reported");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind drive_arming_safety_gate dasg_checker u_dasg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
